// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/swd_pkg.sv =====
package swd_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ENERGY_W     = 32;
  localparam int COUNT_W      = 3;
  localparam int ENERGY_SHIFT = 6;   // square is divided by 64
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  // Register reset values
  localparam logic [ENERGY_W-1:0] HIGH_THRESHOLD_RST = 32'd1000;
  localparam logic [ENERGY_W-1:0] LOW_THRESHOLD_RST  = 32'd100;
  localparam logic [COUNT_W-1:0]  WAKE_COUNT_RST     = 3'd4;
  localparam logic [COUNT_W-1:0]  DECAY_STEP_RST     = 3'd2;

  // Register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_DETECT_ENABLE  = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_LOW_THRESHOLD  = 3'd2,
    REG_WAKE_COUNT     = 3'd3,
    REG_DECAY_STEP     = 3'd4
  } swd_reg_t;

  // Per-sample work handed to the energy stage
  typedef struct packed {
    logic                first;     // first sample of a detecting block
    logic                accum;     // add this sample's difference energy
    logic                last;      // last sample of the block
    logic                mode;      // block runs in detection mode
    logic [SAMPLE_W-1:0] diff_mag;  // |previous - current|
  } swd_term_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] high_threshold;
    logic [ENERGY_W-1:0] low_threshold;
    logic [COUNT_W-1:0]  wake_count;
    logic [COUNT_W-1:0]  decay_step;
  } swd_cfg_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [COUNT_W-1:0]  level;
    logic                pulse;
    logic                flag;
  } swd_result_t;

endpackage

// ===== hw/rtl/sound_activity_wake_detector.sv =====
// Sound activity wake detector. Takes signed 16-bit samples in blocks of
// BLOCK_LEN and returns, for each one, its slot in a BUF_DEPTH ring buffer
// together with block energy and activity status. With detect_enable set at
// a block's first sample, each later sample adds (previous - current)^2 / 64
// to a saturating 32-bit block energy; at the block's last sample the energy
// moves the activity count (up at or above high_threshold, cleared below
// low_threshold, down by decay_step in between) and wake_pulse fires when
// the count reaches wake_count, setting the sticky wake_flag. One sample is
// accepted every clock cycle unless out_stall holds the pipeline; each result
// passes the stage-one register, then the output register. The sample
// difference is registered with the sample, and square-and-accumulate and
// threshold decision lie between them. The user must write registers over the
// APB port only while no sample is in flight; the block does not enforce it.
`include "assert_macros.svh"

module sound_activity_wake_detector
  import swd_pkg::*;
#(
  parameter int BLOCK_LEN = 64,
  parameter int BUF_DEPTH = 2048,
  localparam int ADDR_W   = $clog2(BUF_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample channel in
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  // result channel out
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ADDR_W-1:0]          write_address,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       block_end,
  output logic [ENERGY_W-1:0]        block_energy,
  output logic [COUNT_W-1:0]         activity_level,
  output logic                       wake_pulse,
  output logic                       wake_flag,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  localparam int POS_W = $clog2(BLOCK_LEN);
  localparam int SUM_W = ADDR_W + 10;
  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(BLOCK_LEN - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BUF_DEPTH - 1);
  localparam logic [SUM_W-1:0]  BLOCK_INC = SUM_W'(BLOCK_LEN);
  localparam logic [SUM_W-1:0]  RING_END  = SUM_W'(BUF_DEPTH);

  // Configuration registers
  logic                detect_enable;
  logic [ENERGY_W-1:0] high_threshold;
  logic [ENERGY_W-1:0] low_threshold;
  logic [COUNT_W-1:0]  wake_count;
  logic [COUNT_W-1:0]  decay_step;
  logic                cfg_write;
  swd_reg_t            reg_index;
  swd_cfg_t            cfg;

  // Block context
  logic [POS_W-1:0]          block_position;
  logic [ADDR_W-1:0]         block_start;
  logic [ADDR_W-1:0]         slot;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic                      block_detect_mode;

  // Stage one
  logic                       s1_valid;
  logic [ADDR_W-1:0]          s1_addr;
  logic signed [SAMPLE_W-1:0] s1_sample;
  swd_term_t                  s1_term;

  logic                       in_xfer;
  logic                       advance;
  logic                       first_pos;
  logic                       last_pos;
  logic                       mode_eff;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;
  logic [SUM_W-1:0]           start_sum;
  logic [ADDR_W-1:0]          start_next;
  logic [ADDR_W-1:0]          slot_next;
  swd_result_t                result;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = swd_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable  <= 1'b0;
      high_threshold <= HIGH_THRESHOLD_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      wake_count     <= WAKE_COUNT_RST;
      decay_step     <= DECAY_STEP_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_DETECT_ENABLE:  detect_enable  <= pwdata[0];
        REG_HIGH_THRESHOLD: high_threshold <= pwdata;
        REG_LOW_THRESHOLD:  low_threshold  <= pwdata;
        REG_WAKE_COUNT:     wake_count     <= pwdata[COUNT_W-1:0];
        REG_DECAY_STEP:     decay_step     <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DETECT_ENABLE:  prdata = PDATA_W'(detect_enable);
      REG_HIGH_THRESHOLD: prdata = high_threshold;
      REG_LOW_THRESHOLD:  prdata = low_threshold;
      REG_WAKE_COUNT:     prdata = PDATA_W'(wake_count);
      REG_DECAY_STEP:     prdata = PDATA_W'(decay_step);
      default:            prdata = '0;
    endcase
  end

  assign cfg.high_threshold = high_threshold;
  assign cfg.low_threshold  = low_threshold;
  assign cfg.wake_count     = wake_count;
  assign cfg.decay_step     = decay_step;

  // Pipeline flow
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_xfer  = in_valid && !in_stall;

  // Block position, ring slot and detection mode
  assign first_pos  = (block_position == '0);
  assign last_pos   = (block_position == POS_LAST);
  assign mode_eff   = first_pos ? detect_enable : block_detect_mode;
  assign start_sum  = SUM_W'(block_start) + BLOCK_INC;
  assign start_next = (start_sum >= RING_END) ? '0 : start_sum[ADDR_W-1:0];
  assign slot_next  = last_pos ? start_next :
                      ((slot == ADDR_LAST) ? '0 : slot + ADDR_W'(1));

  // Sample difference magnitude
  assign diff     = {previous_sample[SAMPLE_W-1], previous_sample}
                  - {sample[SAMPLE_W-1], sample};
  assign diff_abs = diff[SAMPLE_W] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_position    <= '0;
      block_start       <= '0;
      slot              <= '0;
      previous_sample   <= '0;
      block_detect_mode <= 1'b0;
    end else if (in_xfer) begin
      block_position    <= last_pos ? '0 : block_position + POS_W'(1);
      slot              <= slot_next;
      block_detect_mode <= mode_eff;
      if (last_pos) begin
        block_start <= start_next;
      end
      if (mode_eff) begin
        previous_sample <= sample;
      end
    end
  end

  // Stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr           <= slot;
      s1_sample         <= sample;
      s1_term.first     <= first_pos && mode_eff;
      s1_term.accum     <= !first_pos && mode_eff;
      s1_term.last      <= last_pos;
      s1_term.mode      <= mode_eff;
      s1_term.diff_mag  <= diff_abs[SAMPLE_W-1:0];
    end
  end

  // Energy and activity
  swd_activity u_activity (
    .clk    (clk),
    .rst    (rst),
    .update (s1_valid && advance),
    .term   (s1_term),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      write_address  <= s1_addr;
      sample_out     <= s1_sample;
      block_end      <= s1_term.last;
      block_energy   <= result.energy;
      activity_level <= result.level;
      wake_pulse     <= result.pulse;
      wake_flag      <= result.flag;
    end
  end

  // Checks
  `ASSERT_PROP(a_pulse_sets_flag, clk, rst, (out_valid && wake_pulse) |-> wake_flag)
  `ASSERT_PROP(a_energy_at_end, clk, rst, (out_valid && !block_end) |-> (block_energy == '0))
  `ASSERT_PROP(a_pulse_at_end, clk, rst, (out_valid && wake_pulse) |-> block_end)
  `ASSERT_NEVER(a_stall_empty, clk, rst, in_stall && !s1_valid)
  `ASSERT_NEVER(a_slot_range, clk, rst, out_valid && (SUM_W'(write_address) >= RING_END))

endmodule

// ===== hw/rtl/swd_activity.sv =====
// Energy accumulation and activity tracking for one sample per cycle on update.
module swd_activity
  import swd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        update,
  input  swd_term_t   term,
  input  swd_cfg_t    cfg,
  output swd_result_t result
);

  logic [ENERGY_W-1:0] energy_accumulator;
  logic [ENERGY_W-1:0] energy_accumulator_next;
  logic [COUNT_W-1:0]  activity_count;
  logic [COUNT_W-1:0]  activity_count_next;
  logic                wake_latch;
  logic                wake_latch_next;
  logic                pulse;

  logic [ENERGY_W-1:0] square;
  logic [ENERGY_W-1:0] step_energy;
  logic [ENERGY_W:0]   sum;
  logic [ENERGY_W-1:0] sum_sat;
  logic [COUNT_W:0]    count_inc;
  logic                check;

  // Difference square scaled by 1/64, saturating accumulate
  assign square      = ENERGY_W'(term.diff_mag) * ENERGY_W'(term.diff_mag);
  assign step_energy = square >> ENERGY_SHIFT;
  assign sum         = {1'b0, energy_accumulator} + {1'b0, step_energy};
  assign sum_sat     = sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];

  always_comb begin
    if (term.first) begin
      energy_accumulator_next = '0;
    end else if (term.accum) begin
      energy_accumulator_next = sum_sat;
    end else begin
      energy_accumulator_next = energy_accumulator;
    end
  end

  // Block-end threshold decision; high test wins when thresholds cross
  assign count_inc = {1'b0, activity_count} + (COUNT_W+1)'(1);
  assign check     = term.last && term.mode;

  always_comb begin
    activity_count_next = activity_count;
    wake_latch_next     = wake_latch;
    pulse               = 1'b0;
    if (check) begin
      priority if (energy_accumulator_next >= cfg.high_threshold) begin
        if (count_inc >= {1'b0, cfg.wake_count}) begin
          activity_count_next = cfg.wake_count;
          pulse               = 1'b1;
          wake_latch_next     = 1'b1;
        end else begin
          activity_count_next = count_inc[COUNT_W-1:0];
        end
      end else if (energy_accumulator_next < cfg.low_threshold) begin
        activity_count_next = '0;
      end else begin
        activity_count_next = (activity_count > cfg.decay_step) ?
                              activity_count - cfg.decay_step : '0;
      end
    end
  end

  assign result.energy = check ? energy_accumulator_next : '0;
  assign result.level  = activity_count_next;
  assign result.pulse  = pulse;
  assign result.flag   = wake_latch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_accumulator <= '0;
      activity_count     <= '0;
      wake_latch         <= 1'b0;
    end else if (update) begin
      energy_accumulator <= energy_accumulator_next;
      activity_count     <= activity_count_next;
      wake_latch         <= wake_latch_next;
    end
  end

endmodule
